// File: sv/fsfp_pkg.sv
package fsfp_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'hFE;
  localparam logic [7:0] TRAILER_BYTE = 8'hAA;
  localparam logic [3:0] FRAME_LENGTH = 4'd9;

  // Frame byte positions; position zero means hunting for a header.
  localparam logic [3:0] POS_HUNT  = 4'd0;
  localparam logic [3:0] POS_X_LO  = 4'd2;
  localparam logic [3:0] POS_X_HI  = 4'd3;
  localparam logic [3:0] POS_Y_LO  = 4'd4;
  localparam logic [3:0] POS_Y_HI  = 4'd5;
  localparam logic [3:0] POS_CHECK = 4'd6;
  localparam logic [3:0] POS_QUAL  = 4'd7;
  localparam logic [3:0] POS_LAST  = FRAME_LENGTH - 4'd1;

  typedef enum logic [1:0] {
    ST_GOOD         = 2'd0,
    ST_BAD_TRAILER  = 2'd1,
    ST_BAD_CHECKSUM = 2'd2
  } status_t;

  // Registered input byte handed from the input stage to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

endpackage

// File: sv/fsfp_if.sv
interface fsfp_in_if import fsfp_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fsfp_out_if import fsfp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] motion_x;
  logic signed [15:0] motion_y;
  logic [7:0]         quality;

  modport source (output valid, output status, output motion_x, output motion_y,
                  output quality, input ready);
  modport sink (input valid, input status, input motion_x, input motion_y,
                input quality, output ready);
endinterface

// File: sv/flow_sensor_frame_parser_unit.sv
// Path: a frame's trailer byte passes the input register and then the parser's result
// register, from which the frame result is presented on the output.
// Throughput: one byte per cycle; the only stall is a trailer byte arriving while
// the result register still holds an untaken result.
// Reset: synchronous active-low rst_n returns the parser to header hunting and
// empties both the input and result registers.
module flow_sensor_frame_parser_unit import fsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fsfp_in_if.sink    in_ch,
  fsfp_out_if.source out_ch
);

  byte_stage_t stage;
  logic        stage_ready;

  fsfp_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .stage       (stage),
    .stage_ready (stage_ready)
  );

  fsfp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .stage_ready (stage_ready),
    .out_ch      (out_ch)
  );

endmodule

// File: sv/fsfp_in_reg.sv
module fsfp_in_reg import fsfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fsfp_in_if.sink     in_ch,
  output byte_stage_t stage,
  input  logic        stage_ready
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       take;

  // The register refills in the same cycle that the parser drains it.
  assign in_ch.ready = !valid_r || stage_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (stage_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_ch.rx_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

// File: sv/fsfp_parser.sv
module fsfp_parser import fsfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  byte_stage_t stage,
  output logic        stage_ready,
  fsfp_out_if.source  out_ch
);

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic [7:0]  qual_r, qual_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic [15:0] mx_r, mx_nxt;
  logic [15:0] my_r, my_nxt;
  logic [7:0]  oq_r, oq_nxt;

  logic        hunting;
  logic        last_byte;
  logic        take;
  logic        emit;
  logic [7:0]  b;

  assign b         = stage.data;
  assign hunting   = (pos_r == POS_HUNT) || (pos_r >= FRAME_LENGTH);
  assign last_byte = (pos_r == POS_LAST);

  // Only the trailer byte needs room in the result register.
  assign stage_ready = !(last_byte && out_valid_r && !out_ch.ready);
  assign take        = stage.valid && stage_ready;
  assign emit        = take && last_byte;

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    chk_nxt  = chk_r;
    qual_nxt = qual_r;
    if (take) begin
      if (hunting) begin
        if (b == HEADER_BYTE) begin
          pos_nxt = 4'd1;
          sum_nxt = 8'd0;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end else begin
        case (pos_r)
          POS_X_LO:  x_nxt    = {x_r[15:8], b};
          POS_X_HI:  x_nxt    = {b, x_r[7:0]};
          POS_Y_LO:  y_nxt    = {y_r[15:8], b};
          POS_Y_HI:  y_nxt    = {b, y_r[7:0]};
          POS_CHECK: chk_nxt  = b;
          POS_QUAL:  qual_nxt = b;
          default:   ;
        endcase
        if (pos_r inside {[POS_X_LO:POS_Y_HI]}) begin
          sum_nxt = sum_r + b;
        end
        if (last_byte) begin
          pos_nxt = POS_HUNT;
        end else begin
          pos_nxt = pos_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    oq_nxt        = oq_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      mx_nxt        = x_r;
      my_nxt        = y_r;
      oq_nxt        = qual_r;
      // A bad trailer takes precedence over a checksum mismatch.
      if (b != TRAILER_BYTE) begin
        status_nxt = ST_BAD_TRAILER;
      end else if (sum_r != chk_r) begin
        status_nxt = ST_BAD_CHECKSUM;
      end else begin
        status_nxt = ST_GOOD;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    chk_r    <= chk_nxt;
    qual_r   <= qual_nxt;
    status_r <= status_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    oq_r     <= oq_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.motion_x = $signed(mx_r);
  assign out_ch.motion_y = $signed(my_r);
  assign out_ch.quality  = oq_r;

endmodule
